[src/sse_pkg.sv]
// Shared types, widths and constants of the spline segment evaluator.
package sse_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int FRAC_BITS       = 16;
	localparam int BLEND_FRAC_BITS = 16;

	localparam int BLEND_W = BLEND_FRAC_BITS + 1;
	localparam int WIDE_W  = COORD_WIDTH + 6;
	localparam int PROD_W  = WIDE_W + BLEND_W + 1;

	localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << BLEND_FRAC_BITS;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// angle reduction: whole degrees reduced by reciprocal multiply
	localparam int DEG_FULL_INT = 360;
	localparam int DEG_HALF_INT = 180;
	localparam int MAG_W        = COORD_WIDTH + 1;
	localparam int INT_W        = MAG_W - FRAC_BITS;
	localparam int RECIP_SH     = INT_W + 8;
	localparam int QE_W         = 2 * INT_W;
	localparam int Q_W          = QE_W - RECIP_SH;
	localparam int REM_W        = 10;
	localparam int DEG_INT_W    = 9;
	localparam int DEG_W        = DEG_INT_W + FRAC_BITS;
	localparam logic [INT_W-1:0] RECIP =
		INT_W'((64'd1 << RECIP_SH) / 64'd360);
	localparam logic [DEG_W-1:0] DEG_HALF = DEG_W'(DEG_HALF_INT) << FRAC_BITS;

	localparam int LATENCY = 11;

	typedef enum logic [1:0] {
		MODE_LINEAR  = 2'd0,
		MODE_BEZIER  = 2'd1,
		MODE_HERMITE = 2'd2,
		MODE_EULER   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [BLEND_W-1:0]            blend_position;
		logic signed [COORD_WIDTH-1:0] point_a;
		logic signed [COORD_WIDTH-1:0] point_b;
		logic signed [COORD_WIDTH-1:0] point_c;
		logic signed [COORD_WIDTH-1:0] point_d;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] curve_value;
		logic                          saturated;
	} out_item_t;

	typedef struct packed {
		logic             neg;
		logic [DEG_W-1:0] mag;
	} euler_dist_t;

endpackage

[src/sse_scale_lane.sv]
// One blend lane: base + delta * u, rounded half away from zero, two stages.
module sse_scale_lane
	import sse_pkg::*;
(
	input  logic                     clk,
	input  logic signed [WIDE_W-1:0] base,
	input  logic signed [WIDE_W-1:0] delta,
	input  logic [BLEND_W-1:0]       blend,
	output logic signed [WIDE_W-1:0] value
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (BLEND_FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [WIDE_W-1:0] base_s1;
	logic signed [PROD_W-1:0] bias;
	logic signed [PROD_W-1:0] biased;
	logic signed [PROD_W-1:0] shifted;
	logic signed [WIDE_W-1:0] value_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= delta * $signed({1'b0, blend});
		base_s1 <= base;
	end

	// negative products round with one less bias, so ties go away from zero
	always_comb begin
		bias    = prod_s1[PROD_W-1] ? HALF - PROD_W'(1) : HALF;
		biased  = prod_s1 + bias;
		shifted = biased >>> BLEND_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		value_s2 <= base_s1 + shifted[WIDE_W-1:0];
	end

	assign value = value_s2;

endmodule

[src/sse_euler_dist.sv]
// Shortest-path angle distance: |a - d| mod 360, folded to [0,180], six stages.
module sse_euler_dist
	import sse_pkg::*;
(
	input  logic                     clk,
	input  logic signed [WIDE_W-1:0] diff,
	output euler_dist_t              angle_dist
);

	logic [WIDE_W-1:0]     mag_full;
	logic                  pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic [INT_W-1:0]      int_s2, int_s3;
	logic [FRAC_BITS-1:0]  frac_s2, frac_s3, frac_s4;
	logic [QE_W-1:0]       qe_s3;
	logic [Q_W-1:0]        quot;
	logic [INT_W-1:0]      quot_x;
	logic [INT_W-1:0]      rem_full;
	logic [REM_W-1:0]      rem_s4;
	logic [REM_W-1:0]      rem_adj;
	logic [DEG_W-1:0]      m_s5;
	logic signed [DEG_W:0] off_s6;
	logic [DEG_W:0]        off_abs;
	euler_dist_t           dist_s7;

	assign mag_full = diff[WIDE_W-1] ? WIDE_W'(-diff) : WIDE_W'(diff);

	always_ff @(posedge clk) begin
		pos_s2  <= !diff[WIDE_W-1] && (diff != '0);
		int_s2  <= mag_full[MAG_W-1:FRAC_BITS];
		frac_s2 <= mag_full[FRAC_BITS-1:0];
	end

	// quotient estimate by reciprocal, low by at most one
	always_ff @(posedge clk) begin
		qe_s3   <= QE_W'(int_s2) * QE_W'(RECIP);
		int_s3  <= int_s2;
		frac_s3 <= frac_s2;
		pos_s3  <= pos_s2;
	end

	always_comb begin
		quot     = qe_s3[QE_W-1:RECIP_SH];
		quot_x   = INT_W'(quot) * INT_W'(DEG_FULL_INT);
		rem_full = int_s3 - quot_x;
	end

	always_ff @(posedge clk) begin
		rem_s4  <= rem_full[REM_W-1:0];
		frac_s4 <= frac_s3;
		pos_s4  <= pos_s3;
	end

	assign rem_adj = (rem_s4 >= REM_W'(DEG_FULL_INT)) ?
		rem_s4 - REM_W'(DEG_FULL_INT) : rem_s4;

	always_ff @(posedge clk) begin
		m_s5   <= {rem_adj[DEG_INT_W-1:0], frac_s4};
		pos_s5 <= pos_s4;
	end

	always_ff @(posedge clk) begin
		off_s6 <= $signed({1'b0, m_s5}) - $signed({1'b0, DEG_HALF});
		pos_s6 <= pos_s5;
	end

	assign off_abs = off_s6[DEG_W] ? (DEG_W+1)'(-off_s6) : (DEG_W+1)'(off_s6);

	always_ff @(posedge clk) begin
		dist_s7.mag <= DEG_HALF - off_abs[DEG_W-1:0];
		dist_s7.neg <= pos_s6;
	end

	assign angle_dist = dist_s7;

endmodule

[src/spline_segment_evaluator_top.sv]
// Top level of the spline segment evaluator: input capture, three blend levels, saturation.
//
// Usage
//   Input channel: drive item and raise start; the item is taken at the rising
//   edge where start is high and busy is low. busy stays low: the pipeline takes
//   one item every cycle, so items may follow back to back without a gap.
//   Result channel: result_valid is high for exactly one cycle with result; the
//   receiver must take it then, as there is no way to hold results off.
//   Configuration: cfg_wr_en with cfg_wr_data writes curve_mode (0 linear,
//   1 cubic Bezier, 2 cubic Hermite, 3 Euler shortest path). Write it only
//   while no item is in flight; each item carries the mode it entered with.
// Timing
//   Throughput is one item per cycle. The depth comes from three chained blend
//   levels (de Casteljau levels or Horner steps), each a prepare stage, a
//   multiply stage and a round-and-add stage, between the input capture stage
//   and the saturating output register.
// Reset
//   arst_n clears all valid bits at once and sets curve_mode to cubic Bezier.
module spline_segment_evaluator_top
	import sse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        result_valid,
	output out_item_t   result,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data
);

	typedef struct packed {
		mode_t                    mode;
		logic [BLEND_W-1:0]       u;
		logic signed [WIDE_W-1:0] a;
		logic signed [WIDE_W-1:0] b;
		logic signed [WIDE_W-1:0] dad;
	} side_t;

	mode_t curve_mode_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_s7, valid_s8, valid_s9, valid_s10, valid_s11;

	logic signed [WIDE_W-1:0] a_in, b_in, c_in, d_in;
	logic [BLEND_W-1:0]       u_in;

	mode_t                    mode_s1;
	logic [BLEND_W-1:0]       u_s1;
	logic signed [WIDE_W-1:0] a_s1, b_s1, c_s1, d_s1, dad_s1, bc_s1, diff_s1;

	side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic signed [WIDE_W-1:0] base1_d [3];
	logic signed [WIDE_W-1:0] delta1_d [3];
	logic signed [WIDE_W-1:0] base1_s2 [3];
	logic signed [WIDE_W-1:0] delta1_s2 [3];
	logic signed [WIDE_W-1:0] res1_s4 [3];
	logic signed [WIDE_W-1:0] k2, k3;

	logic signed [WIDE_W-1:0] base2_d [2];
	logic signed [WIDE_W-1:0] delta2_d [2];
	logic signed [WIDE_W-1:0] base2_s5 [2];
	logic signed [WIDE_W-1:0] delta2_s5 [2];
	logic signed [WIDE_W-1:0] res2_s7 [2];

	euler_dist_t              edist_s7;
	logic signed [WIDE_W-1:0] edist_ext;
	logic signed [WIDE_W-1:0] base3_d, delta3_d;
	logic signed [WIDE_W-1:0] base3_s8, delta3_s8;
	logic [BLEND_W-1:0]       u_s8;
	logic signed [WIDE_W-1:0] res3_s10;

	logic      in_range;
	out_item_t result_d;
	out_item_t result_s11;

	// every cycle takes a new item
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= MODE_BEZIER;
		end else if (cfg_wr_en) begin
			curve_mode_q <= mode_t'(cfg_wr_data);
		end
	end

	// advance the valid bits with their items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
		end
	end

	// capture: widen the points, clamp u to one, form d - a, a - d and b + c
	always_comb begin
		a_in = WIDE_W'(item.point_a);
		b_in = WIDE_W'(item.point_b);
		c_in = WIDE_W'(item.point_c);
		d_in = WIDE_W'(item.point_d);
		u_in = (item.blend_position > BLEND_ONE) ? BLEND_ONE : item.blend_position;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= curve_mode_q;
		u_s1    <= u_in;
		a_s1    <= a_in;
		b_s1    <= b_in;
		c_s1    <= c_in;
		d_s1    <= d_in;
		dad_s1  <= d_in - a_in;
		bc_s1   <= b_in + c_in;
		diff_s1 <= a_in - d_in;
	end

	// level one: three Bezier lanes, or the inner Horner step on lane zero
	always_comb begin
		k3 = bc_s1 - (dad_s1 <<< 1);
		k2 = dad_s1 + (dad_s1 <<< 1) - b_s1 - bc_s1;
		base1_d[1]  = b_s1;
		delta1_d[1] = c_s1 - b_s1;
		base1_d[2]  = c_s1;
		delta1_d[2] = d_s1 - c_s1;
		case (mode_s1)
			MODE_HERMITE: begin
				base1_d[0]  = k2;
				delta1_d[0] = k3;
			end
			default: begin
				base1_d[0]  = a_s1;
				delta1_d[0] = b_s1 - a_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		side_s2.mode <= mode_s1;
		side_s2.u    <= u_s1;
		side_s2.a    <= a_s1;
		side_s2.b    <= b_s1;
		side_s2.dad  <= dad_s1;
		base1_s2     <= base1_d;
		delta1_s2    <= delta1_d;
	end

	// hold the side values alongside the lanes
	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
	end

	for (genvar i = 0; i < 3; i++) begin : g_lvl1
		sse_scale_lane u_lane (
			.clk   (clk),
			.base  (base1_s2[i]),
			.delta (delta1_s2[i]),
			.blend (side_s2.u),
			.value (res1_s4[i])
		);
	end

	// level two: two Bezier lanes, or the middle Horner step
	always_comb begin
		base2_d[1]  = res1_s4[1];
		delta2_d[1] = res1_s4[2] - res1_s4[1];
		case (side_s4.mode)
			MODE_HERMITE: begin
				base2_d[0]  = side_s4.b;
				delta2_d[0] = res1_s4[0];
			end
			default: begin
				base2_d[0]  = res1_s4[0];
				delta2_d[0] = res1_s4[1] - res1_s4[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		base2_s5  <= base2_d;
		delta2_s5 <= delta2_d;
	end

	for (genvar i = 0; i < 2; i++) begin : g_lvl2
		sse_scale_lane u_lane (
			.clk   (clk),
			.base  (base2_s5[i]),
			.delta (delta2_s5[i]),
			.blend (side_s5.u),
			.value (res2_s7[i])
		);
	end

	sse_euler_dist u_euler (
		.clk        (clk),
		.diff       (diff_s1),
		.angle_dist (edist_s7)
	);

	// level three: the final blend for every mode
	always_comb begin
		edist_ext = edist_s7.neg ? -$signed(WIDE_W'(edist_s7.mag))
		                         : $signed(WIDE_W'(edist_s7.mag));
		case (side_s7.mode)
			MODE_LINEAR: begin
				base3_d  = side_s7.a;
				delta3_d = side_s7.dad;
			end
			MODE_HERMITE: begin
				base3_d  = side_s7.a;
				delta3_d = res2_s7[0];
			end
			MODE_EULER: begin
				base3_d  = side_s7.a;
				delta3_d = edist_ext;
			end
			default: begin
				base3_d  = res2_s7[0];
				delta3_d = res2_s7[1] - res2_s7[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		base3_s8  <= base3_d;
		delta3_s8 <= delta3_d;
		u_s8      <= side_s7.u;
	end

	sse_scale_lane u_lvl3 (
		.clk   (clk),
		.base  (base3_s8),
		.delta (delta3_s8),
		.blend (u_s8),
		.value (res3_s10)
	);

	// saturate: the value fits when the coordinate's sign bit and all bits above it agree
	always_comb begin
		in_range = (&res3_s10[WIDE_W-1:COORD_WIDTH-1]) || !(|res3_s10[WIDE_W-1:COORD_WIDTH-1]);
		result_d.saturated   = !in_range;
		result_d.curve_value = in_range ? res3_s10[COORD_WIDTH-1:0]
		                     : (res3_s10[WIDE_W-1] ? COORD_MIN : COORD_MAX);
	end

	always_ff @(posedge clk) begin
		result_s11 <= result_d;
	end

	assign result       = result_s11;
	assign result_valid = valid_s11;

endmodule

[src/sse_checker.sv]
// Port-level checker of the spline segment evaluator and its bind.
module sse_checker
	import sse_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input in_item_t   item,
	input logic       result_valid,
	input out_item_t  result,
	input logic       cfg_wr_en,
	input logic [1:0] cfg_wr_data
);

	// every accepted item yields its result a fixed time later
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY result_valid)
		else $error("accepted item gave no result at the fixed latency");

	// no result without an item accepted at the fixed latency before
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted item");

	// a saturated result sits on one of the range bounds
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |->
			(result.curve_value == COORD_MAX || result.curve_value == COORD_MIN))
		else $error("saturated result not at a range bound");

	// the pipeline never refuses an item
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("item refused while the pipeline takes one per cycle");

endmodule

bind spline_segment_evaluator_top sse_checker u_sse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result),
	.cfg_wr_en    (cfg_wr_en),
	.cfg_wr_data  (cfg_wr_data)
);
